// ----- rtl/core/mzg_pkg.sv -----
// ----------------------------------------------------------------------------
// mzg_pkg
// shared widths, codes and control types of the row-by-row maze generator
// ----------------------------------------------------------------------------
package mzg_pkg;

    localparam int LBL_W  = 6;              // set label width
    localparam int LBL_N  = 1 << LBL_W;     // number of distinct labels
    localparam int DOWN_W = 32;             // down bits / floor walls width
    localparam int JOIN_W = 31;             // join bits / side walls width
    localparam int CFG_W  = 6;              // column count register width

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // row kinds
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_MIDDLE = 2'd1;
    localparam logic [1:0] KIND_LAST   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_FLOOR,
        S_JOIN,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        RING_HOLD,   // keep labels
        RING_SCAN,   // capture used-label mask
        RING_SET,    // write wdata at head, rotate
        RING_FRESH,  // write lowest unused label at head, rotate
        RING_MERGE,  // relabel next column's set to head set, rotate
        RING_ROT     // rotate only
    } ring_op_t;

    typedef struct packed {
        ring_op_t           op;
        logic [LBL_W-1:0]   wdata;
    } ring_ctrl_t;

    typedef struct packed {
        logic [LBL_W-1:0]   lbl0;   // label of current column
        logic [LBL_W-1:0]   lbl1;   // label of next column
        logic [LBL_W-1:0]   fresh;  // lowest label not in the scanned mask
    } ring_stat_t;

endpackage

// ----- rtl/core/mzg_if.sv -----
// ----------------------------------------------------------------------------
// mzg interfaces
// valid/ready channels for rows, wall results and configuration
// ----------------------------------------------------------------------------
interface mzg_row_if
    import mzg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        row_kind;
    logic [DOWN_W-1:0] down_bits;
    logic [JOIN_W-1:0] join_bits;

    modport source (output valid, output row_kind, output down_bits, output join_bits,
                    input ready);
    modport sink   (input valid, input row_kind, input down_bits, input join_bits,
                    output ready);
endinterface

interface mzg_wall_if
    import mzg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DOWN_W-1:0] floor_walls;
    logic [JOIN_W-1:0] side_walls;

    modport source (output valid, output floor_walls, output side_walls, input ready);
    modport sink   (input valid, input floor_walls, input side_walls, output ready);
endinterface

interface mzg_cfg_if
    import mzg_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] cols_in_use;

    modport source (output valid, output cols_in_use, input ready);
    modport sink   (input valid, input cols_in_use, output ready);
endinterface

// ----- rtl/core/mzg_ring.sv -----
// ----------------------------------------------------------------------------
// mzg_ring
// rotating row of column labels with parallel merge and fresh-label search
// ----------------------------------------------------------------------------
module mzg_ring
    import mzg_pkg::*;
#(
    parameter int MAX_COLS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ring_ctrl_t                        ctrl,
    input  logic [$clog2(MAX_COLS)-1:0]       cnt,
    input  logic [$clog2(MAX_COLS+1)-1:0]     n,
    output ring_stat_t                        stat
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int SW = CW + 1;

    logic [LBL_W-1:0] lbl_reg  [MAX_COLS];
    logic [LBL_W-1:0] lbl_next [MAX_COLS];
    logic [LBL_N-1:0] used_reg;
    logic [LBL_N-1:0] used_next;
    logic [LBL_N-1:0] free_onehot;
    logic [LBL_W-1:0] fresh;
    logic [MAX_COLS-1:0] act;

    // position p holds column cnt + p (mod MAX_COLS)
    always_comb
    begin
        logic [SW-1:0] col;
        for (int p = 0; p < MAX_COLS; p++)
        begin
            col = SW'(cnt) + SW'(p);
            if (col >= SW'(MAX_COLS))
            begin
                col = col - SW'(MAX_COLS);
            end
            act[p] = (col < SW'(n));
        end
    end

    // labels held by the other active columns
    always_comb
    begin
        used_next = '0;
        for (int p = 1; p < MAX_COLS; p++)
        begin
            if (act[p])
            begin
                used_next[lbl_reg[p]] = 1'b1;
            end
        end
    end

    // lowest clear bit of the mask
    assign free_onehot = ~used_reg & (used_reg + LBL_N'(1));

    always_comb
    begin
        fresh = '0;
        for (int k = 0; k < LBL_N; k++)
        begin
            if (free_onehot[k])
            begin
                fresh = fresh | LBL_W'(k);
            end
        end
    end

    always_comb
    begin
        logic [LBL_W-1:0] tmp [MAX_COLS];
        logic             rotate;
        for (int p = 0; p < MAX_COLS; p++)
        begin
            tmp[p] = lbl_reg[p];
        end
        rotate = 1'b0;
        unique case (ctrl.op)
            RING_HOLD,
            RING_SCAN:
            begin
                rotate = 1'b0;
            end
            RING_SET:
            begin
                tmp[0] = ctrl.wdata;
                rotate = 1'b1;
            end
            RING_FRESH:
            begin
                tmp[0] = fresh;
                rotate = 1'b1;
            end
            RING_MERGE:
            begin
                for (int p = 0; p < MAX_COLS; p++)
                begin
                    if (act[p] && lbl_reg[p] == lbl_reg[1])
                    begin
                        tmp[p] = lbl_reg[0];
                    end
                end
                rotate = 1'b1;
            end
            RING_ROT:
            begin
                rotate = 1'b1;
            end
            default:
            begin
                rotate = 1'b0;
            end
        endcase
        for (int p = 0; p < MAX_COLS; p++)
        begin
            lbl_next[p] = rotate ? tmp[(p + 1) % MAX_COLS] : tmp[p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_COLS; p++)
            begin
                lbl_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < MAX_COLS; p++)
            begin
                lbl_reg[p] <= lbl_next[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == RING_SCAN)
        begin
            used_reg <= used_next;
        end
    end

    assign stat.lbl0  = lbl_reg[0];
    assign stat.lbl1  = lbl_reg[1];
    assign stat.fresh = fresh;

endmodule

// ----- rtl/core/mzg_seq.sv -----
// ----------------------------------------------------------------------------
// mzg_seq
// row sequencer: column walk, floor and join decisions, result register
// ----------------------------------------------------------------------------
module mzg_seq
    import mzg_pkg::*;
#(
    parameter int MAX_COLS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        row_kind,
    input  logic [DOWN_W-1:0]                 down_bits,
    input  logic [JOIN_W-1:0]                 join_bits,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [DOWN_W-1:0]                 floor_walls,
    output logic [JOIN_W-1:0]                 side_walls,
    input  logic [$clog2(MAX_COLS+1)-1:0]     n,
    output logic [$clog2(MAX_COLS)-1:0]       cnt,
    output ring_ctrl_t                        ctrl,
    input  ring_stat_t                        stat
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int SW = CW + 1;

    seq_state_t          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          kind_reg, kind_next;
    logic [DOWN_W-1:0]   down_reg, down_next;
    logic [JOIN_W-1:0]   join_reg, join_next;
    logic [LBL_W-1:0]    run_reg, run_next;
    logic                opened_reg, opened_next;
    logic [LBL_W-1:0]    label_reg, label_next;
    logic [MAX_COLS-1:0] floor_acc_reg, floor_acc_next;
    logic [MAX_COLS-1:0] side_acc_reg, side_acc_next;
    logic [DOWN_W-1:0]   floor_out_reg, floor_out_next;
    logic [JOIN_W-1:0]   side_out_reg, side_out_next;

    logic [SW-1:0]       cw, cp1, nn;
    logic                last;
    logic [LBL_W-1:0]    run_cur;
    logic                opened_tmp, bnd, wall_f;
    logic                merge;
    logic [MAX_COLS+DOWN_W-1:0] floor_ext;
    logic [MAX_COLS+JOIN_W-1:0] side_ext;

    assign cw   = SW'(cnt_reg);
    assign cp1  = SW'(cnt_reg) + SW'(1);
    assign nn   = SW'(n);
    assign last = (cnt_reg == CW'(MAX_COLS - 1));

    // floor decision for the current column
    always_comb
    begin
        logic w;
        run_cur    = (cnt_reg == '0) ? stat.lbl0 : run_reg;
        opened_tmp = opened_reg || !down_reg[0];
        bnd        = (cp1 < nn) && (run_cur != stat.lbl1);
        w          = down_reg[0];
        if (bnd && !opened_tmp)
        begin
            w = 1'b0;
        end
        if (cp1 == nn && !opened_tmp)
        begin
            w = 1'b0;
        end
        wall_f = (cw < nn) && w;
    end

    assign merge = (cp1 < nn) && (stat.lbl0 != stat.lbl1)
                   && ((kind_reg == KIND_LAST) || join_reg[0]);

    assign floor_ext = {{DOWN_W{1'b0}}, floor_acc_reg};
    assign side_ext  = {{JOIN_W{1'b0}}, side_acc_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        down_next      = down_reg;
        join_next      = join_reg;
        run_next       = run_reg;
        opened_next    = opened_reg;
        label_next     = label_reg;
        floor_acc_next = floor_acc_reg;
        side_acc_next  = side_acc_reg;
        floor_out_next = floor_out_reg;
        side_out_next  = side_out_reg;
        ctrl.op        = RING_HOLD;
        ctrl.wdata     = '0;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next       = '0;
                    phase_next     = 1'b0;
                    kind_next      = row_kind;
                    down_next      = down_bits;
                    join_next      = join_bits;
                    opened_next    = 1'b0;
                    label_next     = '0;
                    floor_acc_next = '0;
                    side_acc_next  = '0;
                    unique case (row_kind)
                        KIND_FIRST:  state_next = S_FIRST;
                        KIND_MIDDLE,
                        KIND_LAST:   state_next = S_FLOOR;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_FIRST:
            begin
                ctrl.op       = RING_SET;
                ctrl.wdata    = (cw < nn) ? label_reg : '0;
                side_acc_next = {(cp1 < nn) && join_reg[0], side_acc_reg[MAX_COLS-1:1]};
                if ((cp1 < nn) && join_reg[0])
                begin
                    label_next = label_reg + LBL_W'(1);
                end
                join_next = join_reg >> 1;
                cnt_next  = cnt_reg + CW'(1);
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_FLOOR:
            begin
                if (!phase_reg)
                begin
                    ctrl.op    = RING_SCAN;
                    phase_next = 1'b1;
                end
                else
                begin
                    ctrl.op        = wall_f ? RING_FRESH : RING_ROT;
                    floor_acc_next = {wall_f, floor_acc_reg[MAX_COLS-1:1]};
                    if (cw < nn)
                    begin
                        opened_next = bnd ? 1'b0 : opened_tmp;
                        run_next    = bnd ? stat.lbl1 : run_cur;
                    end
                    down_next  = down_reg >> 1;
                    phase_next = 1'b0;
                    cnt_next   = cnt_reg + CW'(1);
                    if (last)
                    begin
                        cnt_next   = '0;
                        state_next = S_JOIN;
                    end
                end
            end
            S_JOIN:
            begin
                ctrl.op       = merge ? RING_MERGE : RING_ROT;
                side_acc_next = {(cp1 < nn) && !merge, side_acc_reg[MAX_COLS-1:1]};
                join_next     = join_reg >> 1;
                cnt_next      = cnt_reg + CW'(1);
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    floor_out_next = floor_ext[DOWN_W-1:0];
                    side_out_next  = side_ext[JOIN_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        down_reg      <= down_next;
        join_reg      <= join_next;
        run_reg       <= run_next;
        opened_reg    <= opened_next;
        label_reg     <= label_next;
        floor_acc_reg <= floor_acc_next;
        side_acc_reg  <= side_acc_next;
        floor_out_reg <= floor_out_next;
        side_out_reg  <= side_out_next;
    end

    assign cnt         = cnt_reg;
    assign out_valid   = out_valid_reg;
    assign floor_walls = floor_out_reg;
    assign side_walls  = side_out_reg;

endmodule

// ----- rtl/core/row_by_row_maze_generator_core.sv -----
// a first row walks the ring once (state FIRST), a middle or last row walks it for the floor
// pass (FLOOR) and again for the join pass (JOIN); row kind three goes straight to DONE
// the floor pass does a label scan and then a fresh-label write or a rotate for each column, the join pass
// visits each column once; every pass covers all MAX_COLS ring slots
// a new row is taken the cycle after a result is registered; reset clears all labels
// at once, sets the column count to 32 and leaves no result pending
// ----------------------------------------------------------------------------
// row_by_row_maze_generator_core
// builds a perfect maze one row per beat, keeping one set label per column
// ----------------------------------------------------------------------------
module row_by_row_maze_generator_core
    import mzg_pkg::*;
#(
    parameter int MAX_COLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    mzg_row_if.sink     rows,
    mzg_wall_if.source  walls,
    mzg_cfg_if.sink     cfg
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int NW = $clog2(MAX_COLS + 1);

    // column count register; the user must write it only while the block is idle, the block does not enforce this
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic [6:0]       cols_wide;
    logic [6:0]       n_wide;
    logic [NW-1:0]    n;

    logic [CW-1:0]    cnt;
    ring_ctrl_t       ctrl;
    ring_stat_t       stat;

    assign cfg.ready = 1'b1;
    assign cols_next = (cfg.valid) ? cfg.cols_in_use : cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
        end
    end

    // saturate the column count into 2..MAX_COLS
    assign cols_wide = {1'b0, cols_reg};

    always_comb
    begin
        if (cols_wide < 7'd2)
        begin
            n_wide = 7'd2;
        end
        else if (cols_wide > 7'(MAX_COLS))
        begin
            n_wide = 7'(MAX_COLS);
        end
        else
        begin
            n_wide = cols_wide;
        end
    end

    assign n = n_wide[NW-1:0];

    // sequencer walks the columns and decides walls
    mzg_seq #(
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rows.valid),
        .in_ready    (rows.ready),
        .row_kind    (rows.row_kind),
        .down_bits   (rows.down_bits),
        .join_bits   (rows.join_bits),
        .out_valid   (walls.valid),
        .out_ready   (walls.ready),
        .floor_walls (walls.floor_walls),
        .side_walls  (walls.side_walls),
        .n           (n),
        .cnt         (cnt),
        .ctrl        (ctrl),
        .stat        (stat)
    );

    // label ring: the current column always sits at the head slot
    mzg_ring #(
        .MAX_COLS (MAX_COLS)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cnt   (cnt),
        .n     (n),
        .stat  (stat)
    );

endmodule

// ----- rtl/core/mzg_checker.sv -----
// ----------------------------------------------------------------------------
// mzg_checker
// port-level checks of the maze generator handshakes
// ----------------------------------------------------------------------------
module mzg_checker
    import mzg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DOWN_W-1:0] floor_walls,
    input  logic [JOIN_W-1:0] side_walls
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(floor_walls)
                                       && $stable(side_walls)))
    else $error("result beat dropped or changed while stalled");

    // one row at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("row taken while another row is in work");

    // a result never appears the cycle right after a row beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result shown too early after a row beat");

endmodule

bind row_by_row_maze_generator_core mzg_checker u_mzg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rows.valid),
    .in_ready    (rows.ready),
    .out_valid   (walls.valid),
    .out_ready   (walls.ready),
    .floor_walls (walls.floor_walls),
    .side_walls  (walls.side_walls)
);

// ----- tb/tb_row_by_row_maze_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_by_row_maze_generator_core
// self-checking bench for the row-by-row maze generator: a directed table of
// rows, then mostly well-formed random mazes under a sweep of column counts,
// every untyped wall beat compared against an in-bench model of the column labels
// ----------------------------------------------------------------------------
module tb_row_by_row_maze_generator_core;
    import mzg_pkg::*;

    localparam int MAX_COLS = 32;

    // row kind with no effect, not named in the package
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int DIR_ROWS      = 19;
    localparam int RANDOM_ROWS   = 1300;
    localparam int CALM_FROM     = 1150;     // no idling on either side past this many rows
    localparam int PHASE_ROWS    = 100;      // rows per column-count setting
    localparam int PRESSURE_AT   = 200;      // wall beats seen before the long hold-off
    localparam int PRESSURE_LEN  = 500;      // cycles the wall sink holds ready low
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 3 * MAX_COLS + 8;
    localparam int NUM_SWEEP     = 12;

    typedef struct {
        logic [DOWN_W-1:0] floor_walls;
        logic [JOIN_W-1:0] side_walls;
    } wall_beat_t;

    // one row beat; typed rows carry an expectation that is obvious by inspection
    typedef struct {
        logic [1:0]        row_kind;
        logic [DOWN_W-1:0] down_bits;
        logic [JOIN_W-1:0] join_bits;
        bit                typed;
        logic [DOWN_W-1:0] exp_floor;
        logic [JOIN_W-1:0] exp_side;
    } row_vec_t;

    logic clk;
    logic rst_n;

    mzg_row_if  row_bus ();
    mzg_wall_if wall_bus ();
    mzg_cfg_if  cfg_bus ();

    row_by_row_maze_generator_core #(
        .MAX_COLS (MAX_COLS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rows  (row_bus),
        .walls (wall_bus),
        .cfg   (cfg_bus)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    logic [LBL_W-1:0] col_label [MAX_COLS];  // mirrored set label per column
    logic [CFG_W-1:0] cols_reg;              // mirrored column count register
    wall_beat_t       walls_due [$];         // expected wall beats, oldest first
    int unsigned      rows_sent;
    int unsigned      walls_seen;
    int unsigned      err_count;
    int unsigned      cycle_cnt;
    bit               calm;                  // end of run: no idling anywhere

    // directed rows, all with the column count at its reset value of 32
    row_vec_t dir_rows [DIR_ROWS] = '{
        // row kind three right after reset: no effect, both fields zero
        '{KIND_NONE,   32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'h0, 31'h0},
        // middle and last rows before any first row: labels form one run
        '{KIND_MIDDLE, 32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 32'h0, 31'h0},
        '{KIND_LAST,   32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 32'h0, 31'h0},
        // first row, no walls: floor field zero, side walls straight from join bits
        '{KIND_FIRST,  32'hFFFF_FFFF, 31'h0000_0000, 1'b1, 32'h0, 31'h0},
        '{KIND_MIDDLE, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0, 32'h0, 31'h0},
        // first row walled everywhere: every column its own set
        '{KIND_FIRST,  32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 32'h0, 31'h7FFF_FFFF},
        // all floors open, nothing joined: every side wall stays
        '{KIND_MIDDLE, 32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0, 31'h7FFF_FFFF},
        '{KIND_MIDDLE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 32'h0, 31'h0},
        '{KIND_NONE,   32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0, 31'h0},
        '{KIND_MIDDLE, 32'h0F0F_0F0F, 31'h3333_3333, 1'b0, 32'h0, 31'h0},
        '{KIND_MIDDLE, 32'h8000_0001, 31'h4000_0001, 1'b0, 32'h0, 31'h0},
        '{KIND_LAST,   32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 32'h0, 31'h0},
        // first row with one run, then a last row: all neighbours equal, all side walls
        '{KIND_FIRST,  32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0, 31'h0},
        '{KIND_LAST,   32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0, 31'h7FFF_FFFF},
        '{KIND_FIRST,  32'h0000_0000, 31'h2AAA_AAAA, 1'b1, 32'h0, 31'h2AAA_AAAA},
        '{KIND_MIDDLE, 32'h5555_5555, 31'h1555_5555, 1'b0, 32'h0, 31'h0},
        '{KIND_MIDDLE, 32'hFFFF_0000, 31'h7FFF_0000, 1'b0, 32'h0, 31'h0},
        '{KIND_LAST,   32'h1234_5678, 31'h0000_0000, 1'b0, 32'h0, 31'h0},
        '{KIND_LAST,   32'h0000_0000, 31'h7FFF_FFFF, 1'b0, 32'h0, 31'h0}
    };

    // column counts walked by the random phases, extremes among them
    logic [CFG_W-1:0] cfg_sweep [NUM_SWEEP] = '{
        6'd0, 6'd32, 6'd1, 6'd2, 6'd63, 6'd3, 6'd17, 6'd31, 6'd33, 6'd5, 6'd2, 6'd32
    };

    // ------------------------------------------------------------------------
    // maze model
    // ------------------------------------------------------------------------

    // column count in effect, saturated to 2..MAX_COLS
    function automatic int unsigned live_cols();
        int unsigned n;
        n = cols_reg;
        if (n < 2) n = 2;
        if (n > MAX_COLS) n = MAX_COLS;
        return n;
    endfunction

    // lowest label held by no active column other than the one being relabeled
    function automatic logic [LBL_W-1:0] lowest_free_label(int unsigned n, int unsigned skip);
        logic [LBL_N-1:0] used;
        used = '0;
        for (int unsigned c = 0; c < n; c++)
            if (c != skip) used[col_label[c]] = 1'b1;
        for (int unsigned c = 0; c < LBL_N; c++)
            if (!used[c]) return LBL_W'(c);
        return '0;
    endfunction

    // walls for one row beat; advances the mirrored labels
    function automatic void predict_walls(input  logic [1:0]        kind,
                                          input  logic [DOWN_W-1:0] down_v,
                                          input  logic [JOIN_W-1:0] join_v,
                                          output logic [DOWN_W-1:0] floor_w,
                                          output logic [JOIN_W-1:0] side_w);
        int unsigned      n;
        logic [LBL_W-1:0] run_lbl;
        logic [LBL_W-1:0] lbl_a;
        logic [LBL_W-1:0] lbl_b;
        logic [LBL_W-1:0] next_lbl;
        bit               opened;
        bit               wall;
        bit               want;
        n       = live_cols();
        floor_w = '0;
        side_w  = '0;
        if (kind == KIND_FIRST) begin
            // runs between walls get labels 0, 1, 2, ... from the left
            next_lbl = '0;
            for (int unsigned i = 0; i < MAX_COLS; i++) begin
                col_label[i] = (i < n) ? next_lbl : '0;
                if (i + 1 < n && join_v[i]) begin
                    side_w[i] = 1'b1;
                    next_lbl  = next_lbl + 1'b1;
                end
            end
        end else if (kind == KIND_MIDDLE || kind == KIND_LAST) begin
            // floor: each run of equal labels keeps at least one opening
            run_lbl = col_label[0];
            opened  = 1'b0;
            for (int unsigned c = 0; c < n; c++) begin
                wall = down_v[c];
                if (!wall) opened = 1'b1;
                if (c + 1 < n && run_lbl != col_label[c + 1]) begin
                    if (!opened) wall = 1'b0;
                    opened  = 1'b0;
                    run_lbl = col_label[c + 1];
                end
                if (c + 1 == n && !opened) wall = 1'b0;
                if (wall) begin
                    col_label[c] = lowest_free_label(n, c);
                    floor_w[c]   = 1'b1;
                end
            end
            // joins: merge the right set into the left one
            for (int unsigned i = 0; i + 1 < n; i++) begin
                lbl_a = col_label[i];
                lbl_b = col_label[i + 1];
                want  = (kind == KIND_LAST) || join_v[i];
                if (lbl_a != lbl_b && want) begin
                    for (int unsigned j = 0; j < n; j++)
                        if (col_label[j] == lbl_b) col_label[j] = lbl_a;
                end else begin
                    side_w[i] = 1'b1;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // random word, often sparse, dense or all one value so runs vary in length
    function automatic logic [31:0] pick_bits();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom() & $urandom() & $urandom();
            3:       return $urandom() | $urandom() | $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic row_vec_t random_row(input logic [1:0] kind);
        row_vec_t r;
        r.row_kind  = kind;
        r.down_bits = pick_bits();
        r.join_bits = JOIN_W'(pick_bits());
        r.typed     = 1'b0;
        r.exp_floor = '0;
        r.exp_side  = '0;
        return r;
    endfunction

    // offer one row beat, predict its walls once it is taken
    task automatic send_row(input row_vec_t r);
        wall_beat_t due;
        // idle burst ahead of the beat
        if (!calm && $urandom_range(0, 4) == 0) begin
            row_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        row_bus.valid     <= 1'b1;
        row_bus.row_kind  <= r.row_kind;
        row_bus.down_bits <= r.down_bits;
        row_bus.join_bits <= r.join_bits;
        do @(posedge clk); while (!row_bus.ready);
        // the model always runs so the labels stay in step
        predict_walls(r.row_kind, r.down_bits, r.join_bits, due.floor_walls, due.side_walls);
        if (r.typed) begin
            due.floor_walls = r.exp_floor;
            due.side_walls  = r.exp_side;
        end
        walls_due.push_back(due);
        rows_sent++;
        if (rows_sent >= CALM_FROM) calm = 1'b1;
    endtask

    // column count write, only once every wall beat is back
    task automatic write_cols(input logic [CFG_W-1:0] cols_v);
        row_bus.valid <= 1'b0;
        while (walls_due.size() != 0) @(posedge clk);
        // let the result register settle back to idle
        repeat (4) @(posedge clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.cols_in_use <= cols_v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        cols_reg = cols_v;
    endtask

    // ------------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles, %0d wall beats still due",
                 $time, cycle_cnt, walls_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // wall sink: checks each beat and throttles ready
    // ------------------------------------------------------------------------
    initial begin : wall_sink
        int unsigned stall_left;
        int unsigned hold_left;
        bit          pressure_done;
        wall_beat_t  due;
        stall_left    = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (wall_bus.valid && wall_bus.ready) begin
                walls_seen++;
                if (walls_due.size() == 0) begin
                    $display("%0t: wall beat with none due, actual floor %h side %h",
                             $time, wall_bus.floor_walls, wall_bus.side_walls);
                    err_count++;
                end else begin
                    due = walls_due.pop_front();
                    if (wall_bus.floor_walls !== due.floor_walls) begin
                        $display("%0t: floor_walls mismatch, expected %h, actual %h",
                                 $time, due.floor_walls, wall_bus.floor_walls);
                        err_count++;
                    end
                    if (wall_bus.side_walls !== due.side_walls) begin
                        $display("%0t: side_walls mismatch, expected %h, actual %h",
                                 $time, due.side_walls, wall_bus.side_walls);
                        err_count++;
                    end
                end
            end
            // one long hold-off so the block backs up and stalls the row side
            if (!pressure_done && walls_seen == PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                wall_bus.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                wall_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                wall_bus.ready <= 1'b0;
            end else begin
                wall_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // row source: directed table, then random mazes per column count
    // ------------------------------------------------------------------------
    initial begin : row_source
        int unsigned      phase;
        int unsigned      phase_end;
        int unsigned      mid_rows;
        logic [CFG_W-1:0] cols_v;

        // every input known from time zero
        rst_n               = 1'b0;
        row_bus.valid       = 1'b0;
        row_bus.row_kind    = KIND_FIRST;
        row_bus.down_bits   = '0;
        row_bus.join_bits   = '0;
        wall_bus.ready      = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.cols_in_use = CFG_RESET;
        rows_sent           = 0;
        walls_seen          = 0;
        err_count           = 0;
        calm                = 1'b0;

        // bench mirror of the reset state
        cols_reg = CFG_RESET;
        for (int i = 0; i < MAX_COLS; i++) col_label[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send_row(dir_rows[k]);

        // random phases, each opened by a column count write while idle
        phase = 0;
        while (rows_sent < DIR_ROWS + RANDOM_ROWS) begin
            cols_v = (phase < NUM_SWEEP) ? cfg_sweep[phase] : CFG_W'($urandom_range(0, 63));
            write_cols(cols_v);
            phase_end = rows_sent + PHASE_ROWS;
            while (rows_sent < phase_end && rows_sent < DIR_ROWS + RANDOM_ROWS) begin
                if ($urandom_range(0, 99) < 85) begin
                    // well-formed maze: first row, a stack of middle rows, last row
                    send_row(random_row(KIND_FIRST));
                    mid_rows = $urandom_range(1, 12);
                    for (int unsigned m = 0; m < mid_rows; m++) begin
                        if ($urandom_range(0, 19) == 0)
                            send_row(random_row(KIND_NONE));
                        send_row(random_row(KIND_MIDDLE));
                    end
                    send_row(random_row(KIND_LAST));
                end else begin
                    // noise: any kind in any order, broken sequences included
                    repeat ($urandom_range(1, 6))
                        send_row(random_row(2'($urandom_range(0, 3))));
                end
            end
            phase++;
        end
        row_bus.valid <= 1'b0;

        // drain, then give the block its full latency to show a stray beat
        while (walls_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
